[src/mfde_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_HEIGHT * ROW_BYTES;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int COORD_W       = 11;

    localparam int GLYPH_COUNT = 37;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_DOTS  = GLYPH_COLS * GLYPH_ROWS;
    localparam int BLANK_GLYPH = 36;
    localparam int PCT_DOTS    = 13;

    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_PIXEL = 3'd1,
        OP_HLINE = 3'd2,
        OP_VLINE = 3'd3,
        OP_RECT  = 3'd4,
        OP_FILL  = 3'd5,
        OP_GLYPH = 3'd6,
        OP_READ  = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        GK_FONT,
        GK_PCT,
        GK_NONE
    } glyph_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RD,
        ST_WR,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              on_screen;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        mask;
    } pix_loc_t;

    localparam logic [7:0] FONT [GLYPH_COUNT][GLYPH_COLS] = '{
        '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e}, '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4b, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1e},
        '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e}, '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c},
        '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01},
        '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a}, '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f},
        '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01},
        '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f}, '{8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f},
        '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e}, '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e}, '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46},
        '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01},
        '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f}, '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f},
        '{8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
        '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] PCT_DX [PCT_DOTS] = '{
        3'd0, 3'd1, 3'd0, 3'd1, 3'd4, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam logic [2:0] PCT_DY [PCT_DOTS] = '{
        3'd0, 3'd0, 3'd1, 3'd1, 3'd5, 3'd5, 3'd6, 3'd6, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5
    };

    function automatic glyph_kind_t glyph_kind(input logic [7:0] code);
        glyph_kind_t k;
        if ((code >= 8'd48 && code <= 8'd57) || (code >= 8'd65 && code <= 8'd90) ||
            (code >= 8'd97 && code <= 8'd122) || code == 8'd32) begin
            k = GK_FONT;
        end else if (code == 8'd37) begin
            k = GK_PCT;
        end else begin
            k = GK_NONE;
        end
        return k;
    endfunction

    function automatic logic [5:0] glyph_index(input logic [7:0] code);
        logic [7:0] g;
        if (code >= 8'd48 && code <= 8'd57) begin
            g = code - 8'd48;
        end else if (code >= 8'd65 && code <= 8'd90) begin
            g = code - 8'd55;
        end else if (code >= 8'd97 && code <= 8'd122) begin
            g = code - 8'd87;
        end else begin
            g = 8'(BLANK_GLYPH);
        end
        return g[5:0];
    endfunction

endpackage

`default_nettype wire

[src/mfde_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/mfde_map.sv]
`timescale 1ns / 1ps
`default_nettype none

module mfde_map (
    input  wire logic [mfde_pkg::COORD_W-1:0] px,
    input  wire logic [mfde_pkg::COORD_W-1:0] py,
    output mfde_pkg::pix_loc_t                loc
);

    logic [mfde_pkg::COORD_W-1:0] mx;
    logic [mfde_pkg::COORD_W-1:0] my;
    logic                         x_ok;
    logic                         y_ok;

    always_comb begin
        x_ok = !px[mfde_pkg::COORD_W-1] &&
               (px < mfde_pkg::COORD_W'(mfde_pkg::SCREEN_WIDTH));
        y_ok = !py[mfde_pkg::COORD_W-1] &&
               (py < mfde_pkg::COORD_W'(mfde_pkg::SCREEN_HEIGHT));
        // both axes mirrored
        mx = mfde_pkg::COORD_W'(mfde_pkg::SCREEN_WIDTH - 1) - px;
        my = mfde_pkg::COORD_W'(mfde_pkg::SCREEN_HEIGHT - 1) - py;
        loc.on_screen = x_ok && y_ok;
        loc.addr = mfde_pkg::ADDR_W'(32'(my) * mfde_pkg::ROW_BYTES + 32'(mx >> 3));
        loc.mask = 8'h80 >> mx[2:0];
    end

endmodule

`default_nettype wire

[src/mono_framebuffer_draw_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Clear walks ST_CLEAR over all 512 bytes; a byte read passes ST_READ and ST_READ_DATA.
// Drawing reads then writes each on-screen pixel, steps past off-screen ones, and sets up
// each pass (a line, rectangle edge, font dot or percent dot) in ST_SETUP, then ST_DONE.
// One item at a time; all pixel work goes through one read-modify-write port.
// Reset (aresetn low, synchronous) starts a clearing pass of the whole
// framebuffer; s_ready stays low until it ends.

module mono_framebuffer_draw_engine (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_opcode,
    input  wire logic [8:0] s_x_pos,
    input  wire logic [8:0] s_y_pos,
    input  wire logic [7:0] s_span_width,
    input  wire logic [7:0] s_span_height,
    input  wire logic       s_pixel_color,
    input  wire logic [7:0] s_glyph_code,
    input  wire logic [3:0] s_glyph_scale,
    input  wire logic [4:0] s_read_row,
    input  wire logic [3:0] s_read_column,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data
);

    localparam int CW = mfde_pkg::COORD_W;
    localparam int AW = mfde_pkg::ADDR_W;

    mfde_pkg::state_t    state_reg, state_next;
    mfde_pkg::opcode_t   op_reg, op_next;
    mfde_pkg::glyph_kind_t kind_reg, kind_next;
    logic [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic [7:0]    w_reg, w_next, h_reg, h_next;
    logic          color_reg, color_next;
    logic [5:0]    gidx_reg, gidx_next;
    logic [3:0]    scale_reg, scale_next;
    logic [4:0]    rrow_reg, rrow_next;
    logic [3:0]    rcol_reg, rcol_next;
    logic [5:0]    phase_reg, phase_next;
    logic [2:0]    gcol_reg, gcol_next, grow_reg, grow_next;
    logic [CW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [7:0]    pw_reg, pw_next, ph_reg, ph_next;
    logic [7:0]    i_reg, i_next, j_reg, j_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    mask_reg, mask_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          clr_cmd_reg, clr_cmd_next;
    logic [7:0]    data_reg, data_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;

    // pass description for the current phase
    logic [5:0]    n_phases;
    logic          pass_en;
    logic [CW-1:0] pass_x, pass_y;
    logic [7:0]    pass_w, pass_h;
    logic [CW-1:0] dot_off_x, dot_off_y;

    logic          accept;
    logic          last_i, last_j, last_phase;
    logic          rd_in_range;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] px, py;
    mfde_pkg::pix_loc_t loc;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == mfde_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_read_data = m_data_reg;

    assign px = bx_reg + {{(CW-8){1'b0}}, i_reg};
    assign py = by_reg + {{(CW-8){1'b0}}, j_reg};

    mfde_map u_map (
        .px  (px),
        .py  (py),
        .loc (loc)
    );

    mfde_ram #(
        .WIDTH (8),
        .DEPTH (mfde_pkg::STORE_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_in_range = (32'(rrow_reg) < mfde_pkg::SCREEN_HEIGHT) &&
                         (32'(rcol_reg) < mfde_pkg::ROW_BYTES);
    assign rd_addr = AW'(32'(rrow_reg) * mfde_pkg::ROW_BYTES + 32'(rcol_reg));

    assign last_i     = ({1'b0, i_reg} + 9'd1) == {1'b0, pw_reg};
    assign last_j     = ({1'b0, j_reg} + 9'd1) == {1'b0, ph_reg};
    assign last_phase = (phase_reg == n_phases);

    always_comb begin
        ram_we    = (state_reg == mfde_pkg::ST_CLEAR) || (state_reg == mfde_pkg::ST_WR);
        ram_waddr = (state_reg == mfde_pkg::ST_CLEAR) ? clr_reg : addr_reg;
        ram_wdata = 8'h00;
        if (state_reg == mfde_pkg::ST_WR) begin
            ram_wdata = color_reg ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
        end
        ram_raddr = (state_reg == mfde_pkg::ST_READ) ? rd_addr : loc.addr;
    end

    // pass setup
    always_comb begin
        dot_off_x = CW'(gcol_reg) * CW'(scale_reg);
        dot_off_y = CW'(grow_reg) * CW'(scale_reg);
        n_phases  = 6'd1;
        pass_en   = 1'b1;
        pass_x    = x_reg;
        pass_y    = y_reg;
        pass_w    = 8'd1;
        pass_h    = 8'd1;
        case (op_reg)
            mfde_pkg::OP_PIXEL: begin
            end
            mfde_pkg::OP_HLINE: begin
                pass_w = w_reg;
            end
            mfde_pkg::OP_VLINE: begin
                pass_h = h_reg;
            end
            mfde_pkg::OP_FILL: begin
                pass_w = w_reg;
                pass_h = h_reg;
            end
            mfde_pkg::OP_RECT: begin
                n_phases = 6'd4;
                case (phase_reg[1:0])
                    2'd0: pass_w = w_reg;
                    2'd1: begin
                        pass_w = w_reg;
                        pass_y = y_reg + {{(CW-8){1'b0}}, h_reg} - CW'(1);
                    end
                    2'd2: pass_h = h_reg;
                    default: begin
                        pass_h = h_reg;
                        pass_x = x_reg + {{(CW-8){1'b0}}, w_reg} - CW'(1);
                    end
                endcase
            end
            mfde_pkg::OP_GLYPH: begin
                if (kind_reg == mfde_pkg::GK_FONT) begin
                    n_phases = 6'(mfde_pkg::GLYPH_DOTS);
                    pass_en  = mfde_pkg::FONT[gidx_reg][gcol_reg][grow_reg];
                    pass_x   = x_reg + dot_off_x;
                    pass_y   = y_reg + dot_off_y;
                    pass_w   = {4'd0, scale_reg};
                    pass_h   = {4'd0, scale_reg};
                end else if (kind_reg == mfde_pkg::GK_PCT) begin
                    n_phases = 6'(mfde_pkg::PCT_DOTS);
                    pass_x   = x_reg + CW'(mfde_pkg::PCT_DX[phase_reg[3:0]]);
                    pass_y   = y_reg + CW'(mfde_pkg::PCT_DY[phase_reg[3:0]]);
                end else begin
                    n_phases = 6'd0;
                end
            end
            default: n_phases = 6'd0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mfde_pkg::ST_CLEAR: begin
                if (clr_reg == AW'(mfde_pkg::STORE_BYTES - 1)) begin
                    state_next = clr_cmd_reg ? mfde_pkg::ST_DONE : mfde_pkg::ST_IDLE;
                end
            end
            mfde_pkg::ST_IDLE: begin
                if (accept) begin
                    if (mfde_pkg::opcode_t'(s_opcode) == mfde_pkg::OP_CLEAR) begin
                        state_next = mfde_pkg::ST_CLEAR;
                    end else if (mfde_pkg::opcode_t'(s_opcode) == mfde_pkg::OP_READ) begin
                        state_next = mfde_pkg::ST_READ;
                    end else begin
                        state_next = mfde_pkg::ST_SETUP;
                    end
                end
            end
            mfde_pkg::ST_SETUP: begin
                if (last_phase) begin
                    state_next = mfde_pkg::ST_DONE;
                end else if (pass_en && pass_w != 8'd0 && pass_h != 8'd0) begin
                    state_next = mfde_pkg::ST_RD;
                end
            end
            mfde_pkg::ST_RD: begin
                if (loc.on_screen) begin
                    state_next = mfde_pkg::ST_WR;
                end else if (last_i && last_j) begin
                    state_next = mfde_pkg::ST_SETUP;
                end
            end
            mfde_pkg::ST_WR: begin
                state_next = (last_i && last_j) ? mfde_pkg::ST_SETUP : mfde_pkg::ST_RD;
            end
            mfde_pkg::ST_READ:      state_next = mfde_pkg::ST_READ_DATA;
            mfde_pkg::ST_READ_DATA: state_next = mfde_pkg::ST_DONE;
            mfde_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = mfde_pkg::ST_IDLE;
                end
            end
            default: state_next = mfde_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        op_next      = op_reg;
        kind_next    = kind_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        color_next   = color_reg;
        gidx_next    = gidx_reg;
        scale_next   = scale_reg;
        rrow_next    = rrow_reg;
        rcol_next    = rcol_reg;
        phase_next   = phase_reg;
        gcol_next    = gcol_reg;
        grow_next    = grow_reg;
        bx_next      = bx_reg;
        by_next      = by_reg;
        pw_next      = pw_reg;
        ph_next      = ph_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        addr_next    = addr_reg;
        mask_next    = mask_reg;
        clr_next     = clr_reg;
        clr_cmd_next = clr_cmd_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mfde_pkg::ST_CLEAR: begin
                clr_next = clr_reg + AW'(1);
            end
            mfde_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next      = mfde_pkg::opcode_t'(s_opcode);
                    kind_next    = mfde_pkg::glyph_kind(s_glyph_code);
                    gidx_next    = mfde_pkg::glyph_index(s_glyph_code);
                    x_next       = {{(CW-9){s_x_pos[8]}}, s_x_pos};
                    y_next       = {{(CW-9){s_y_pos[8]}}, s_y_pos};
                    w_next       = s_span_width;
                    h_next       = s_span_height;
                    color_next   = s_pixel_color ||
                                   (mfde_pkg::opcode_t'(s_opcode) == mfde_pkg::OP_GLYPH);
                    scale_next   = s_glyph_scale;
                    rrow_next    = s_read_row;
                    rcol_next    = s_read_column;
                    phase_next   = 6'd0;
                    gcol_next    = 3'd0;
                    grow_next    = 3'd0;
                    clr_next     = '0;
                    clr_cmd_next = 1'b1;
                    data_next    = 8'h00;
                end
            end
            mfde_pkg::ST_SETUP: begin
                if (!last_phase) begin
                    bx_next = pass_x;
                    by_next = pass_y;
                    pw_next = pass_w;
                    ph_next = pass_h;
                    i_next  = 8'd0;
                    j_next  = 8'd0;
                    phase_next = phase_reg + 6'd1;
                    if (grow_reg == 3'(mfde_pkg::GLYPH_ROWS - 1)) begin
                        grow_next = 3'd0;
                        gcol_next = gcol_reg + 3'd1;
                    end else begin
                        grow_next = grow_reg + 3'd1;
                    end
                end
            end
            mfde_pkg::ST_RD, mfde_pkg::ST_WR: begin
                addr_next = loc.addr;
                mask_next = loc.mask;
                if (state_reg == mfde_pkg::ST_WR || !loc.on_screen) begin
                    if (!last_i) begin
                        i_next = i_reg + 8'd1;
                    end else begin
                        i_next = 8'd0;
                        j_next = j_reg + 8'd1;
                    end
                end
            end
            mfde_pkg::ST_READ: begin
            end
            mfde_pkg::ST_READ_DATA: begin
                data_next = rd_in_range ? ram_rdata : 8'h00;
            end
            mfde_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = data_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mfde_pkg::ST_CLEAR;
            clr_reg     <= '0;
            clr_cmd_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            clr_cmd_reg <= clr_cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        kind_reg   <= kind_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        color_reg  <= color_next;
        gidx_reg   <= gidx_next;
        scale_reg  <= scale_next;
        rrow_reg   <= rrow_next;
        rcol_reg   <= rcol_next;
        phase_reg  <= phase_next;
        gcol_reg   <= gcol_next;
        grow_reg   <= grow_next;
        bx_reg     <= bx_next;
        by_reg     <= by_next;
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        addr_reg   <= addr_next;
        mask_reg   <= mask_next;
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == mfde_pkg::ST_CLEAR || state_reg == mfde_pkg::ST_WR))
        else $error("framebuffer written outside clear or write state");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("item accepted while previous item in flight");

    a_counters_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfde_pkg::ST_RD) |-> (i_reg < pw_reg && j_reg < ph_reg))
        else $error("pixel counters outside pass");

    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mfde_pkg::ST_WR) |-> $past(state_reg == mfde_pkg::ST_RD))
        else $error("write without preceding read");

endmodule

`default_nettype wire
